// ----- rtl/sle_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_pkg: shared types and constants of the sequential list engine
// Holds the list geometry, command and status codes, and the cell control
// and search-probe structures.
// ----------------------------------------------------------------------------
package sle_pkg;

  localparam int CAPACITY   = 128;
  localparam int ELEM_WIDTH = 32;

  // Count width holds 0..CAPACITY; the compare width also covers an 8-bit position.
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = ((CNT_W > 8) ? CNT_W : 8) + 1;

  typedef logic [CNT_W-1:0]             cnt_t;
  typedef logic [CMP_W-1:0]             cmp_t;
  typedef logic signed [ELEM_WIDTH-1:0] elem_t;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_ERASE  = 2'd1;
  localparam logic [1:0] CMD_GET    = 2'd2;
  localparam logic [1:0] CMD_FIND   = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  // Broadcast control from the sequencer to every cell.
  typedef struct packed {
    logic  ins;    // shift up and write val at lo
    logic  era;    // shift down over lo
    logic  load;   // start a search: every cell tests itself
    logic  step;   // move search results one cell toward cell 0
    logic  get;    // search matches on index lo, else on value
    cnt_t  lo;     // zero-based position of the command
    cnt_t  used;   // current list length
    elem_t val;    // word to insert or search for
  } sle_ctrl_t;

  // Search result travelling down the chain.
  typedef struct packed {
    logic  hit;
    elem_t data;
    cnt_t  idx;
  } sle_probe_t;

  // Input word: sign-extend or truncate the 32-bit value to the element width.
  function automatic elem_t to_elem(input logic [31:0] v);
    return elem_t'($signed(v));
  endfunction

  // Output word: sign-extend or truncate the element to 32 bits.
  function automatic logic [31:0] to_item(input elem_t w);
    return 32'(w);
  endfunction

endpackage

// ----- rtl/sle_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_in_if / sle_out_if: command and result channels
// Valid/ready channels; a transfer happens on a clock edge with both high.
// ----------------------------------------------------------------------------
interface sle_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [7:0]  position;
  logic [31:0] value;

  modport source (output valid, output cmd, output position, output value, input ready);
  modport sink   (input valid, input cmd, input position, input value, output ready);
endinterface

interface sle_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] item;
  logic [7:0]  found_position;
  logic [7:0]  count;

  modport source (output valid, output status, output item, output found_position,
                  output count, input ready);
  modport sink   (input valid, input status, input item, input found_position,
                  input count, output ready);
endinterface

// ----- rtl/sle_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_cell: one list slot
// Holds one list word and one search probe, and trades both with its
// neighbors under the broadcast control.
// ----------------------------------------------------------------------------
module sle_cell
  import sle_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  sle_ctrl_t  ctrl_i,
  input  cnt_t       idx_i,
  input  elem_t      left_entry_i,
  input  elem_t      right_entry_i,
  input  sle_probe_t right_probe_i,
  output elem_t      entry_o,
  output sle_probe_t probe_o
);

  elem_t      entry_q, entry_d;
  sle_probe_t probe_q, probe_d;
  logic       self_hit;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins) begin
      if (idx_i == ctrl_i.lo) begin
        entry_d = ctrl_i.val;
      end else if ((idx_i > ctrl_i.lo) && (idx_i <= ctrl_i.used)) begin
        entry_d = left_entry_i;
      end
    end else if (ctrl_i.era) begin
      if ((idx_i >= ctrl_i.lo) && ((idx_i + cnt_t'(1)) < ctrl_i.used)) begin
        entry_d = right_entry_i;
      end
    end
  end

  assign self_hit = ctrl_i.get ? (idx_i == ctrl_i.lo)
                               : ((idx_i < ctrl_i.used) && (entry_q == ctrl_i.val));

  // A cell keeps the first hit at or above itself; otherwise it takes its neighbor's.
  always_comb begin
    probe_d = probe_q;
    if (ctrl_i.load) begin
      probe_d.hit  = self_hit;
      probe_d.data = entry_q;
      probe_d.idx  = idx_i;
    end else if (ctrl_i.step && !probe_q.hit) begin
      probe_d = right_probe_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
      probe_q <= '0;
    end else begin
      entry_q <= entry_d;
      probe_q <= probe_d;
    end
  end

  assign entry_o = entry_q;
  assign probe_o = probe_q;

endmodule

// ----- rtl/sle_chain.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_chain: row of list cells
// Connects CAPACITY cells into a chain and exposes the head cell.
// ----------------------------------------------------------------------------
module sle_chain
  import sle_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  sle_ctrl_t  ctrl_i,
  output elem_t      head_entry_o,
  output sle_probe_t head_probe_o
);

  elem_t      entry_w [CAPACITY];
  sle_probe_t probe_w [CAPACITY];

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    elem_t      left_w, right_w;
    sle_probe_t rprobe_w;

    if (k == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = entry_w[k-1];
    end

    if (k == CAPACITY - 1) begin : g_last
      assign right_w  = '0;
      assign rprobe_w = '0;
    end else begin : g_mid_r
      assign right_w  = entry_w[k+1];
      assign rprobe_w = probe_w[k+1];
    end

    sle_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl_i),
      .idx_i         (cnt_t'(k)),
      .left_entry_i  (left_w),
      .right_entry_i (right_w),
      .right_probe_i (rprobe_w),
      .entry_o       (entry_w[k]),
      .probe_o       (probe_w[k])
    );
  end

  assign head_entry_o = entry_w[0];
  assign head_probe_o = probe_w[0];

endmodule

// ----- rtl/sequential_list_engine_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequential_list_engine_core: ordered list of signed words
// Keeps up to CAPACITY words in a chain of cells with insert, erase, get and
// find commands, one result per command.
// ----------------------------------------------------------------------------
// Usage:
// Commands arrive on in_i and results leave on out_o, each a valid/ready
// transfer. Every command gives exactly one result carrying a status, an
// item, a found position and the list length after the command.
// Insert, erase and a get with a position outside the list finish at the
// command transfer edge: the result is valid in the next cycle, and while
// the receiver is ready a new command is taken in that cycle, one per cycle.
// A get in range and every find run a search down the cell chain: each cell
// tests itself, then the first hit moves one cell per cycle toward the head.
// The sequencer steps the chain down the list length, then captures the head
// probe into the result; no command is taken during the search.
// Reset clears every list word to zero, the length to zero and the result
// valid flag. While the receiver stalls, the result holds and no new command
// is accepted until the result is taken (a command is taken in the cycle the
// result leaves).
// ----------------------------------------------------------------------------
module sequential_list_engine_core
  import sle_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  sle_in_if.sink    in_i,
  sle_out_if.source out_o
);

  // Sequencer states.
  localparam logic [0:0] S_IDLE = 1'b0;
  localparam logic [0:0] S_SCAN = 1'b1;

  logic [0:0] state_q, state_d;
  cnt_t       used_q, used_d;
  cnt_t       steps_q, steps_d;
  logic       scan_get_q, scan_get_d;

  logic        ov_q, ov_d;
  logic [1:0]  status_q, status_d;
  logic [31:0] item_q, item_d;
  logic [7:0]  fpos_q, fpos_d;
  logic [7:0]  count_q, count_d;

  sle_ctrl_t  ctrl;
  elem_t      head_entry;
  sle_probe_t head_probe;

  logic accept;
  cmp_t pos_w, used_w;
  cnt_t pos_m1, idx_p1;
  logic in_list, ins_ok;

  // The command is taken only when idle and the result register is free now.
  assign in_i.ready = (state_q == S_IDLE) && (!ov_q || out_o.ready);
  assign accept     = in_i.valid && in_i.ready;

  // Range checks in a width that holds both the position and the length.
  assign pos_w   = cmp_t'(in_i.position);
  assign used_w  = cmp_t'(used_q);
  assign pos_m1  = cnt_t'(pos_w - cmp_t'(1));
  assign in_list = (pos_w != '0) && (pos_w <= used_w);
  assign ins_ok  = (pos_w != '0) && (pos_w <= used_w + cmp_t'(1));
  assign idx_p1  = head_probe.idx + cnt_t'(1);

  always_comb begin
    state_d    = state_q;
    used_d     = used_q;
    steps_d    = steps_q;
    scan_get_d = scan_get_q;
    ov_d       = ov_q && !out_o.ready;
    status_d   = status_q;
    item_d     = item_q;
    fpos_d     = fpos_q;
    count_d    = count_q;

    ctrl      = '0;
    ctrl.lo   = pos_m1;
    ctrl.used = used_q;
    ctrl.val  = to_elem(in_i.value);
    ctrl.get  = (state_q == S_IDLE) ? (in_i.cmd == CMD_GET) : scan_get_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          // Defaults for a result finished at this edge.
          status_d = ST_OK;
          item_d   = '0;
          fpos_d   = '0;
          case (in_i.cmd)
            CMD_INSERT: begin
              if (used_q >= cnt_t'(CAPACITY)) begin
                status_d = ST_FULL;
              end else if (!ins_ok) begin
                status_d = ST_RANGE;
              end else begin
                ctrl.ins = 1'b1;
                used_d   = used_q + cnt_t'(1);
              end
              ov_d = 1'b1;
            end
            CMD_ERASE: begin
              if (!in_list) begin
                status_d = ST_RANGE;
              end else begin
                ctrl.era = 1'b1;
                used_d   = used_q - cnt_t'(1);
              end
              ov_d = 1'b1;
            end
            CMD_GET: begin
              if (!in_list) begin
                status_d = ST_RANGE;
                item_d   = to_item(head_entry);
                ov_d     = 1'b1;
              end else begin
                ctrl.load  = 1'b1;
                scan_get_d = 1'b1;
                steps_d    = used_q - cnt_t'(1);
                state_d    = S_SCAN;
              end
            end
            default: begin
              ctrl.load  = 1'b1;
              scan_get_d = 1'b0;
              steps_d    = (used_q == '0) ? '0 : used_q - cnt_t'(1);
              state_d    = S_SCAN;
            end
          endcase
          count_d = 8'(used_d);
        end
      end
      S_SCAN: begin
        if (steps_q == '0) begin
          // The head probe now holds the first hit in the list, if any.
          ov_d    = 1'b1;
          count_d = 8'(used_q);
          if (head_probe.hit) begin
            status_d = ST_OK;
            item_d   = to_item(head_probe.data);
            fpos_d   = scan_get_q ? 8'd0 : 8'(idx_p1);
          end else begin
            status_d = ST_NOTFOUND;
            item_d   = to_item(head_entry);
            fpos_d   = '0;
          end
          state_d = S_IDLE;
        end else begin
          ctrl.step = 1'b1;
          steps_d   = steps_q - cnt_t'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  sle_chain u_chain (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .head_entry_o (head_entry),
    .head_probe_o (head_probe)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      used_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    steps_q    <= steps_d;
    scan_get_q <= scan_get_d;
    status_q   <= status_d;
    item_q     <= item_d;
    fpos_q     <= fpos_d;
    count_q    <= count_d;
  end

  assign out_o.valid          = ov_q;
  assign out_o.status         = status_q;
  assign out_o.item           = item_q;
  assign out_o.found_position = fpos_q;
  assign out_o.count          = count_q;

  // The list length never exceeds the capacity.
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= cnt_t'(CAPACITY))
    else $error("list length above capacity");

  // No result is pending while a search runs.
  a_scan_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> !ov_q)
    else $error("result pending during search");

  // Insert and erase transfers give a result in the next cycle.
  a_edit_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && ((in_i.cmd == CMD_INSERT) || (in_i.cmd == CMD_ERASE))) |=> ov_q)
    else $error("edit command without result");

  // The length only changes on an insert or erase transfer.
  a_used_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!accept || (in_i.cmd == CMD_GET) || (in_i.cmd == CMD_FIND)) |=> $stable(used_q))
    else $error("length changed without an edit");

endmodule
